// File: design/bzf_pkg.sv
// Package for the cubic Bezier flattener: request and result types,
// configuration register codes and sequencer states.
// No dependencies.
`default_nettype none

package bzf_pkg;

  localparam int COORD_W    = 17;
  localparam int COORD_FRAC = 16;
  localparam int PIX_W      = 12;
  localparam int CFG_W      = 12;
  localparam int DEPTH_W    = 3;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  localparam logic [DEPTH_W-1:0] DEPTH_RST  = 3'd4;
  localparam logic [CFG_W-1:0]   WIDTH_RST  = 12'd639;
  localparam logic [CFG_W-1:0]   HEIGHT_RST = 12'd479;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] ctrl1_x;
    logic [COORD_W-1:0] ctrl1_y;
    logic [COORD_W-1:0] ctrl2_x;
    logic [COORD_W-1:0] ctrl2_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] seg_from_x;
    logic [PIX_W-1:0] seg_from_y;
    logic [PIX_W-1:0] seg_to_x;
    logic [PIX_W-1:0] seg_to_y;
    logic             last_segment;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PEN,
    S_PEN2,
    S_CHECK,
    S_SPLIT1,
    S_SPLIT2,
    S_SPLIT3,
    S_MUL,
    S_EMIT,
    S_POP,
    S_LOAD
  } state_t;

  localparam logic [1:0] LAST_IDX = 2'd2;

endpackage

`default_nettype wire

// File: design/cubic_bezier_subdivision_flattener.sv
// Cubic Bezier flattener: de Casteljau midpoint subdivision with a stack
// memory of right halves; emits the control polygon edges of each leaf.
// Throughput is set by the shared pixel multiplier and the stack port, and
// output stalls hold it back; a new curve is taken only once the last
// segment of the current one has been emitted.
// Reset (synchronous, active low) clears sequencer, output valid and config.
`default_nettype none

module cubic_bezier_subdivision_flattener
  import bzf_pkg::*;
#(
  parameter int MAX_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int EXTRA     = 3 * MAX_DEPTH;
  localparam int PW        = COORD_W + EXTRA;
  localparam int LVL_W     = (MAX_DEPTH < 1) ? 1 : $clog2(MAX_DEPTH + 1);
  localparam int MEM_DEPTH = (MAX_DEPTH < 1) ? 1 : MAX_DEPTH;
  localparam int AW        = (MEM_DEPTH < 2) ? 1 : $clog2(MEM_DEPTH);
  localparam int ENT_W     = 6 * PW + LVL_W;
  localparam logic [DEPTH_W-1:0] MAXD = DEPTH_W'(MAX_DEPTH);

  function automatic logic [PW-1:0] mid(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PW:1];
  endfunction

  function automatic logic [PW-1:0] widen(input logic [COORD_W-1:0] c);
    return PW'(c) << EXTRA;
  endfunction

  state_t state_r, state_nxt;

  logic [DEPTH_W-1:0] cfg_depth_r;
  logic [CFG_W-1:0]   cfg_width_r;
  logic [CFG_W-1:0]   cfg_height_r;

  logic [PW-1:0] cur_x_r [3];
  logic [PW-1:0] cur_y_r [3];
  logic [PW-1:0] cur_x_nxt [3];
  logic [PW-1:0] cur_y_nxt [3];
  logic [PW-1:0] pen_x_r, pen_x_nxt;
  logic [PW-1:0] pen_y_r, pen_y_nxt;
  logic [PW-1:0] ab_x_r, bc_x_r, cd_x_r, abc_x_r, bcd_x_r;
  logic [PW-1:0] ab_y_r, bc_y_r, cd_y_r, abc_y_r, bcd_y_r;
  logic [PIX_W-1:0] pen_px_r, pen_px_nxt;
  logic [PIX_W-1:0] pen_py_r, pen_py_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] sp_r, sp_nxt;
  logic [1:0]       idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic [DEPTH_W-1:0] depth_eff;
  logic               out_free;
  logic [PW-1:0]      mul_x, mul_y;
  logic [PIX_W-1:0]   pix_x, pix_y;

  logic             stk_we, stk_re;
  logic [ENT_W-1:0] stk_wdata, stk_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_depth_r  <= DEPTH_RST;
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEPTH:  cfg_depth_r  <= cfg_wdata[DEPTH_W-1:0];
        CFG_WIDTH:  cfg_width_r  <= cfg_wdata;
        CFG_HEIGHT: cfg_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign depth_eff = (cfg_depth_r > MAXD) ? MAXD : cfg_depth_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign mul_x = (state_r == S_PEN) ? pen_x_r : cur_x_r[idx_r];
  assign mul_y = (state_r == S_PEN) ? pen_y_r : cur_y_r[idx_r];

  bzf_pix #(.PW(PW)) u_pix (
    .clk     (clk),
    .scale_x (cfg_width_r),
    .scale_y (cfg_height_r),
    .pt_x    (mul_x),
    .pt_y    (mul_y),
    .pix_x   (pix_x),
    .pix_y   (pix_y)
  );

  // entry: level of the right half, then its three control points
  assign stk_wdata = {level_r + LVL_W'(1),
                      cur_x_r[2], cd_x_r, bcd_x_r, cur_y_r[2], cd_y_r, bcd_y_r};

  bzf_stack #(.DEPTH(MEM_DEPTH), .WIDTH(ENT_W), .AW(AW)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_r[AW-1:0]),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (sp_r[AW-1:0]),
    .rdata (stk_rdata)
  );

  // midpoint stages
  always_ff @(posedge clk) begin
    if (state_r == S_SPLIT1) begin
      ab_x_r <= mid(pen_x_r, cur_x_r[0]);
      ab_y_r <= mid(pen_y_r, cur_y_r[0]);
      bc_x_r <= mid(cur_x_r[0], cur_x_r[1]);
      bc_y_r <= mid(cur_y_r[0], cur_y_r[1]);
      cd_x_r <= mid(cur_x_r[1], cur_x_r[2]);
      cd_y_r <= mid(cur_y_r[1], cur_y_r[2]);
    end
    if (state_r == S_SPLIT2) begin
      abc_x_r <= mid(ab_x_r, bc_x_r);
      abc_y_r <= mid(ab_y_r, bc_y_r);
      bcd_x_r <= mid(bc_x_r, cd_x_r);
      bcd_y_r <= mid(bc_y_r, cd_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      sp_r        <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      sp_r        <= sp_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    pen_x_r    <= pen_x_nxt;
    pen_y_r    <= pen_y_nxt;
    pen_px_r   <= pen_px_nxt;
    pen_py_r   <= pen_py_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    pen_px_nxt    = pen_px_r;
    pen_py_nxt    = pen_py_r;
    level_nxt     = level_r;
    sp_nxt        = sp_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    stk_we        = 1'b0;
    stk_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pen_x_nxt    = widen(in_data.start_x);
          pen_y_nxt    = widen(in_data.start_y);
          cur_x_nxt[0] = widen(in_data.ctrl1_x);
          cur_y_nxt[0] = widen(in_data.ctrl1_y);
          cur_x_nxt[1] = widen(in_data.ctrl2_x);
          cur_y_nxt[1] = widen(in_data.ctrl2_y);
          cur_x_nxt[2] = widen(in_data.end_x);
          cur_y_nxt[2] = widen(in_data.end_y);
          level_nxt    = '0;
          sp_nxt       = '0;
          idx_nxt      = '0;
          state_nxt    = S_PEN;
        end
      end
      S_PEN:  state_nxt = S_PEN2;
      S_PEN2: begin
        pen_px_nxt = pix_x;
        pen_py_nxt = pix_y;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = (DEPTH_W'(level_r) < depth_eff) ? S_SPLIT1 : S_MUL;
      end
      S_SPLIT1: state_nxt = S_SPLIT2;
      S_SPLIT2: state_nxt = S_SPLIT3;
      S_SPLIT3: begin
        stk_we       = 1'b1;
        cur_x_nxt[0] = ab_x_r;
        cur_y_nxt[0] = ab_y_r;
        cur_x_nxt[1] = abc_x_r;
        cur_y_nxt[1] = abc_y_r;
        cur_x_nxt[2] = mid(abc_x_r, bcd_x_r);
        cur_y_nxt[2] = mid(abc_y_r, bcd_y_r);
        level_nxt    = level_r + LVL_W'(1);
        sp_nxt       = sp_r + LVL_W'(1);
        state_nxt    = S_CHECK;
      end
      S_MUL: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.seg_from_x   = pen_px_r;
          out_data_nxt.seg_from_y   = pen_py_r;
          out_data_nxt.seg_to_x     = pix_x;
          out_data_nxt.seg_to_y     = pix_y;
          out_data_nxt.last_segment = (idx_r == LAST_IDX) && (sp_r == '0);
          pen_x_nxt                 = cur_x_r[idx_r];
          pen_y_nxt                 = cur_y_r[idx_r];
          pen_px_nxt                = pix_x;
          pen_py_nxt                = pix_y;
          if (idx_r == LAST_IDX) begin
            idx_nxt = '0;
            if (sp_r == '0) begin
              state_nxt = S_IDLE;
            end else begin
              sp_nxt    = sp_r - LVL_W'(1);
              state_nxt = S_POP;
            end
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_MUL;
          end
        end
      end
      S_POP: begin
        stk_re    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cur_y_nxt[0] = stk_rdata[0*PW +: PW];
        cur_y_nxt[1] = stk_rdata[1*PW +: PW];
        cur_y_nxt[2] = stk_rdata[2*PW +: PW];
        cur_x_nxt[0] = stk_rdata[3*PW +: PW];
        cur_x_nxt[1] = stk_rdata[4*PW +: PW];
        cur_x_nxt[2] = stk_rdata[5*PW +: PW];
        level_nxt    = stk_rdata[6*PW +: LVL_W];
        state_nxt    = S_CHECK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: design/bzf_stack.sv
// Stack memory for pending right halves: one write port, one read port,
// registered read data. Depends on nothing.
`default_nettype none

module bzf_stack #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 174,
  parameter int AW    = 2
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/bzf_pix.sv
// Pixel scaler: registered scale * coordinate for x and y, then floor
// and saturation to the pixel range. Depends on bzf_pkg.
`default_nettype none

module bzf_pix
  import bzf_pkg::*;
#(
  parameter int PW = 29
) (
  input  wire logic             clk,
  input  wire logic [CFG_W-1:0] scale_x,
  input  wire logic [CFG_W-1:0] scale_y,
  input  wire logic [PW-1:0]    pt_x,
  input  wire logic [PW-1:0]    pt_y,
  output logic      [PIX_W-1:0] pix_x,
  output logic      [PIX_W-1:0] pix_y
);

  localparam int SH     = PW - (COORD_W - COORD_FRAC);
  localparam int PROD_W = CFG_W + PW;
  localparam int HI_W   = PROD_W - SH;

  logic [PROD_W-1:0] prod_x_r;
  logic [PROD_W-1:0] prod_y_r;
  logic [HI_W-1:0]   hi_x;
  logic [HI_W-1:0]   hi_y;

  always_ff @(posedge clk) begin
    prod_x_r <= PROD_W'(scale_x) * PROD_W'(pt_x);
    prod_y_r <= PROD_W'(scale_y) * PROD_W'(pt_y);
  end

  assign hi_x  = prod_x_r[PROD_W-1:SH];
  assign hi_y  = prod_y_r[PROD_W-1:SH];
  assign pix_x = (|hi_x[HI_W-1:PIX_W]) ? {PIX_W{1'b1}} : hi_x[PIX_W-1:0];
  assign pix_y = (|hi_y[HI_W-1:PIX_W]) ? {PIX_W{1'b1}} : hi_y[PIX_W-1:0];

endmodule

`default_nettype wire

// File: design/bzf_chk.sv
// Port-level checker for the Bezier flattener, bound to the top level.
// Depends on bzf_pkg.
`default_nettype none

module bzf_chk
  import bzf_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire out_t                 out_data
);

  // a curve in flight blocks the next request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a curve is in flight");

  // a segment that is not the last is only shown while the curve is in flight
  a_mid_seg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_segment) |-> in_stall)
    else $error("idle with an unfinished curve on the output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind cubic_bezier_subdivision_flattener bzf_chk u_bzf_chk (.*);

`default_nettype wire

// File: verif/cubic_bezier_subdivision_flattener_tb.sv
// Testbench for cubic_bezier_subdivision_flattener: curves are split by exact midpoint
// subdivision in the scoreboard and every segment is checked field by field.
// Depends on bzf_pkg and the flattener RTL.
`timescale 1ns / 100ps

module cubic_bezier_subdivision_flattener_tb;
  import bzf_pkg::*;

  localparam int EXT_BITS    = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_LEVELS  = 4;

  class segment_scoreboard;
    out_t             expected_segments[$];
    int               errors;
    int               seen;
    logic [DEPTH_W-1:0] depth_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    function new();
      depth_reg  = DEPTH_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      errors     = 0;
      seen       = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_DEPTH:  depth_reg  = v[DEPTH_W-1:0];
        CFG_WIDTH:  width_reg  = v;
        CFG_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_segments.size();
    endfunction

    function logic [PIX_W-1:0] pixel(logic [CFG_W-1:0] scale, logic [31:0] p);
      logic [47:0] prod;
      prod = (48'(scale) * 48'(p)) >> (COORD_FRAC + EXT_BITS);
      return (prod > 48'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : prod[PIX_W-1:0];
    endfunction

    // one midpoint split, keeping the chosen half; exact thanks to the extra bits
    function void halve(inout logic [31:0] p[4], input bit right_half);
      logic [31:0] ab, bc, cd, abc, bcd, m;
      ab  = (p[0] + p[1]) >> 1;
      bc  = (p[1] + p[2]) >> 1;
      cd  = (p[2] + p[3]) >> 1;
      abc = (ab + bc) >> 1;
      bcd = (bc + cd) >> 1;
      m   = (abc + bcd) >> 1;
      if (right_half) begin
        p[0] = m;
        p[1] = bcd;
        p[2] = cd;
      end else begin
        p[1] = ab;
        p[2] = abc;
        p[3] = m;
      end
    endfunction

    function void flatten_curve(in_t c);
      int          d;
      int          leaves;
      int          leaf;
      int          lvl;
      int          e;
      logic [31:0] px[4];
      logic [31:0] py[4];
      out_t        seg;
      d = (depth_reg > MAX_LEVELS) ? MAX_LEVELS : int'(depth_reg);
      leaves = 1 << d;
      // leaves in depth-first order: bits of the leaf number pick left/right, top level first
      for (leaf = 0; leaf < leaves; leaf++) begin
        px[0] = 32'(c.start_x) << EXT_BITS;
        py[0] = 32'(c.start_y) << EXT_BITS;
        px[1] = 32'(c.ctrl1_x) << EXT_BITS;
        py[1] = 32'(c.ctrl1_y) << EXT_BITS;
        px[2] = 32'(c.ctrl2_x) << EXT_BITS;
        py[2] = 32'(c.ctrl2_y) << EXT_BITS;
        px[3] = 32'(c.end_x) << EXT_BITS;
        py[3] = 32'(c.end_y) << EXT_BITS;
        for (lvl = d - 1; lvl >= 0; lvl--) begin
          halve(px, bit'((leaf >> lvl) & 1));
          halve(py, bit'((leaf >> lvl) & 1));
        end
        for (e = 0; e < 3; e++) begin
          seg.seg_from_x   = pixel(width_reg, px[e]);
          seg.seg_from_y   = pixel(height_reg, py[e]);
          seg.seg_to_x     = pixel(width_reg, px[e+1]);
          seg.seg_to_y     = pixel(height_reg, py[e+1]);
          seg.last_segment = (leaf == leaves - 1) && (e == 2);
          expected_segments.push_back(seg);
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at segment %0d: %s", seen, msg);
      errors++;
    endtask

    task check_segment(out_t got);
      out_t want;
      if (expected_segments.size() == 0) begin
        report("segment with nothing expected");
      end else begin
        want = expected_segments.pop_front();
        if (got.seg_from_x !== want.seg_from_x)
          report($sformatf("seg_from_x %0d, want %0d", got.seg_from_x, want.seg_from_x));
        if (got.seg_from_y !== want.seg_from_y)
          report($sformatf("seg_from_y %0d, want %0d", got.seg_from_y, want.seg_from_y));
        if (got.seg_to_x !== want.seg_to_x)
          report($sformatf("seg_to_x %0d, want %0d", got.seg_to_x, want.seg_to_x));
        if (got.seg_to_y !== want.seg_to_y)
          report($sformatf("seg_to_y %0d, want %0d", got.seg_to_y, want.seg_to_y));
        if (got.last_segment !== want.last_segment)
          report($sformatf("last_segment %0b, want %0b", got.last_segment,
                           want.last_segment));
      end
      seen++;
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEPTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bit                   quiet       = 1'b0;
  int                   cycle_count = 0;
  int                   stall_left  = 0;
  segment_scoreboard    sb          = new();

  cubic_bezier_subdivision_flattener uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // result side: check accepted segments, then pick the stall for the next cycle
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      if (rst_n && out_valid && !out_stall)
        sb.check_segment(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_t mk(int unsigned x0, y0, x1, y1, x2, y2, x3, y3);
    return {17'(x0), 17'(y0), 17'(x1), 17'(y1), 17'(x2), 17'(y2), 17'(x3), 17'(y3)};
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return 17'd65536;
          2:       return {COORD_W{1'b1}};
          default: return 17'd1;
        endcase
      end
      1, 2:    return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_scale();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 12'd1;
      2:       return {CFG_W{1'b1}};
      default: return 12'($urandom_range(1, 4095));
    endcase
  endfunction

  task send_curve(in_t c, bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    sb.flatten_curve(c);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  task program_regs(logic [CFG_W-1:0] depth_word, logic [CFG_W-1:0] w,
                    logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEPTH;
    cfg_wdata <= depth_word;
    sb.set_reg(CFG_DEPTH, depth_word);
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= w;
    sb.set_reg(CFG_WIDTH, w);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= h;
    sb.set_reg(CFG_HEIGHT, h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, full depth
    send_curve(mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_curve(mk(65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536), 1'b0);
    send_curve(mk(131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071), 1'b0);
    send_curve(mk(0, 0, 21845, 21845, 43690, 43690, 65536, 65536), 1'b1);
    send_curve(mk(0, 65536, 0, 0, 65536, 65536, 65536, 0), 1'b1);
    drain();

    // no subdivision, largest screen: saturation and bit patterns
    program_regs(12'd0, 12'd4095, 12'd4095);
    send_curve(mk(131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071), 1'b0);
    send_curve(mk(65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536), 1'b0);
    send_curve(mk('h15555, 'h0AAAA, 'h15555, 'h0AAAA, 'h15555, 'h0AAAA, 'h15555,
                  'h0AAAA), 1'b1);
    send_curve(mk('h0AAAA, 'h15555, 'h0AAAA, 'h15555, 'h0AAAA, 'h15555, 'h0AAAA,
                  'h15555), 1'b1);
    send_curve(mk(1, 1, 65535, 65535, 1, 65535, 65535, 1), 1'b1);
    drain();

    program_regs(12'd1, 12'd1, 12'd1);
    send_curve(mk(65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536), 1'b1);
    send_curve(mk(65535, 65535, 65535, 0, 0, 65535, 65535, 65535), 1'b1);
    drain();

    // depth above the bound, zero screen size
    program_regs(12'hFFF, 12'd0, 12'd0);
    send_curve(mk(1000, 60000, 131071, 200, 30000, 99999, 65536, 12345), 1'b1);
    drain();
    program_regs(12'd5, 12'd2048, 12'd4095);
    send_curve(mk(5, 65536, 40000, 20000, 131071, 0, 7, 65000), 1'b1);
    drain();
    program_regs(12'd6, 12'd4095, 12'd1);
    send_curve(mk(65536, 0, 0, 65536, 65536, 0, 0, 65536), 1'b1);
    drain();
    program_regs(12'd2, 12'd639, 12'd479);
    send_curve(mk(100, 200, 30000, 64000, 50000, 3000, 65536, 65536), 1'b1);
    send_curve(mk(65536, 65536, 0, 0, 65536, 65536, 0, 0), 1'b1);
    drain();
    program_regs(12'd3, 12'd1000, 12'd3000);
    send_curve(mk(32768, 32768, 32769, 32767, 1, 131071, 131071, 1), 1'b1);
    send_curve(mk(12, 34, 56, 78, 90, 123, 456, 789), 1'b1);
    drain();

    for (phase = 0; phase < 5; phase++) begin
      program_regs(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                 : 12'($urandom_range(0, 4)),
                   rand_scale(), rand_scale());
      if (phase == 4)
        quiet = 1'b1;
      for (n = 0; n < 22; n++) begin
        send_curve({rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord()}, 1'b1);
        if (phase == 2 && n == 12)
          drain();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
